// ===== src/thrmp_pkg.sv =====
// Package for the open-loop throttle ramp: word types, mode codes, register
// indexes and fixed constants. No dependencies.
`default_nettype none

package thrmp_pkg;

   typedef enum logic [2:0] {
      MODE_HOLD     = 3'd0,
      MODE_OPEN     = 3'd1,
      MODE_CLOSE    = 3'd2,
      MODE_EXIT     = 3'd3,
      MODE_WAIT_ADC = 3'd4
   } mode_type;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_RAMP_STEP    = 3'd0;
   localparam csr_index_type CSR_OPEN_LIMIT   = 3'd1;
   localparam csr_index_type CSR_CLOSED_LIMIT = 3'd2;
   localparam csr_index_type CSR_PULSE_STEP   = 3'd3;
   localparam csr_index_type CSR_DECAY_STEP   = 3'd4;
   localparam csr_index_type CSR_EXIT_LIMIT   = 3'd5;

   localparam logic [7:0] TIMER_CAP = 8'd250;

   typedef struct packed {
      logic [2:0] control_mode;
      logic       timer_load;
      logic [7:0] timer_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive_voltage;
      logic [7:0]         pulse_ticks_left;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         ramp_step;
      logic signed [15:0] open_limit;
      logic signed [15:0] closed_limit;
      logic [7:0]         pulse_step;
      logic [7:0]         decay_step;
      logic signed [15:0] exit_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/thrmp_csr.sv =====
// Configuration register file for the throttle ramp.
// Depends on thrmp_pkg for the register indexes and the cfg_type bundle.
`default_nettype none

module thrmp_csr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    wr_en,
   input  wire thrmp_pkg::csr_index_type wr_index,
   input  wire logic [15:0]             wr_data,
   output thrmp_pkg::cfg_type           cfg
);
   import thrmp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_RAMP_STEP:    cfg_in.ramp_step    = wr_data[7:0];
            CSR_OPEN_LIMIT:   cfg_in.open_limit   = $signed(wr_data);
            CSR_CLOSED_LIMIT: cfg_in.closed_limit = $signed(wr_data);
            CSR_PULSE_STEP:   cfg_in.pulse_step   = wr_data[7:0];
            CSR_DECAY_STEP:   cfg_in.decay_step   = wr_data[7:0];
            CSR_EXIT_LIMIT:   cfg_in.exit_limit   = $signed(wr_data);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/thrmp_in_stage.sv =====
// Input register for request words of the throttle ramp.
// Depends on thrmp_pkg for req_type.
`default_nettype none

module thrmp_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire thrmp_pkg::req_type req_data,
   output logic                   item_valid,
   output thrmp_pkg::req_type     item,
   input  wire logic              item_take
);
   import thrmp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // Free, or emptying this cycle.
   assign req_ready = !valid_ff || item_take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

`default_nettype wire

// ===== src/thrmp_core.sv =====
// Ramp datapath: voltage and pulse timer state, one step per word, result register.
// Depends on thrmp_pkg for word types, mode codes and the timer cap.
`default_nettype none

module thrmp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire thrmp_pkg::cfg_type cfg,
   input  wire logic               item_valid,
   input  wire thrmp_pkg::req_type item,
   output logic                    item_take,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output thrmp_pkg::rsp_type      rsp_data
);
   import thrmp_pkg::*;

   logic signed [15:0] volt_ff;
   logic signed [15:0] volt_in;
   logic [7:0]         timer_ff;
   logic [7:0]         timer_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      logic [10:0]        step_sum;
      logic signed [17:0] step_ext;
      logic signed [17:0] v_ext;
      logic signed [17:0] sum;
      logic signed [17:0] lim;
      logic [7:0]         t_base;
      logic [7:0]         t_dec;

      step_sum = 11'({3'b000, cfg.ramp_step} * 11'd5) + 11'd2;
      step_ext = $signed({9'b0, step_sum[10:2]});
      v_ext    = $signed({{2{volt_ff[15]}}, volt_ff});
      t_base   = item.timer_load ? item.timer_value : timer_ff;
      t_dec    = t_base - 8'd1;
      sum      = v_ext;
      lim      = '0;
      volt_in  = volt_ff;
      timer_in = t_base;

      unique case (mode_type'(item.control_mode))
         MODE_OPEN: begin
            sum     = v_ext + step_ext;
            lim     = $signed({{2{cfg.open_limit[15]}}, cfg.open_limit});
            volt_in = (sum > lim) ? cfg.open_limit : sum[15:0];
         end
         MODE_CLOSE: begin
            sum     = v_ext - step_ext;
            lim     = $signed({{2{cfg.closed_limit[15]}}, cfg.closed_limit});
            volt_in = (sum < lim) ? cfg.closed_limit : sum[15:0];
         end
         MODE_EXIT: begin
            if (t_base == 8'd0) begin
               // Decay toward the null level.
               sum     = v_ext - $signed({5'b0, cfg.decay_step, 5'b0});
               volt_in = (sum < 18'sd0) ? 16'sd0 : sum[15:0];
            end else begin
               sum      = v_ext + $signed({5'b0, cfg.pulse_step, 5'b0});
               lim      = $signed({{2{cfg.exit_limit[15]}}, cfg.exit_limit});
               volt_in  = (sum > lim) ? cfg.exit_limit : sum[15:0];
               timer_in = (t_dec > TIMER_CAP) ? TIMER_CAP : t_dec;
            end
         end
         MODE_WAIT_ADC: begin
            volt_in = 16'sd0;
         end
         default: begin
            volt_in = volt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volt_ff      <= 16'sd0;
         timer_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            volt_ff  <= volt_in;
            timer_ff <= timer_in;
         end
         if (item_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_data_ff.drive_voltage    <= volt_in;
         rsp_data_ff.pulse_ticks_left <= timer_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/throttle_open_loop_ramp.sv =====
// Open-loop throttle drive ramp, one control tick per request word.
//
// req_*: one word per tick (mode, optional pulse timer preload). rsp_*: one
// word per request with the drive voltage and pulse ticks left after the step.
// csr_*: register writes (index 0..5: ramp_step, open_limit, closed_limit,
// pulse_step, decay_step, exit_limit); csr_ready is always high, and writes
// are to be made while no request is in flight. Unknown indexes are dropped.
//
// A request accepted by the input register waits there until its step loads
// the result register, from which the response word is then taken. Throughput
// is one word per cycle while the receiver does not stall: the step is a
// single add-and-clamp from the state registers, so consecutive ticks follow
// each other without a gap.
// When the receiver stalls, the response holds, one more request waits in the
// input register, and req_ready drops after that.
// Synchronous reset clears voltage, pulse timer, config registers and valids.
// Depends on thrmp_pkg, thrmp_csr, thrmp_in_stage and thrmp_core.
`default_nettype none

module throttle_open_loop_ramp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire thrmp_pkg::req_type       req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output thrmp_pkg::rsp_type            rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire thrmp_pkg::csr_index_type csr_index,
   input  wire logic [15:0]              csr_data
);
   import thrmp_pkg::*;

   cfg_type cfg;
   logic    item_valid;
   req_type item;
   logic    item_take;

   assign csr_ready = 1'b1;

   thrmp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   thrmp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   thrmp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/thrmp_checker.sv =====
// Port-level checks for the throttle ramp, bound to the top level.
// Depends on thrmp_pkg and throttle_open_loop_ramp.
`default_nettype none

module thrmp_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire thrmp_pkg::rsp_type       rsp_data,
   input wire logic                     csr_valid,
   input wire logic                     csr_ready
);
   import thrmp_pkg::*;

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A response out of an empty output comes from a word accepted into the input register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without an accepted request");

   // Register writes never stall.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind throttle_open_loop_ramp thrmp_checker u_thrmp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

`default_nettype wire
